// File: src/tcw_pkg.sv
// Shared constants, codes and control structs for the text console writer.
package tcw_pkg;

    // Screen geometry
    localparam int COLUMNS = 80;
    localparam int LINES   = 25;
    localparam int CELLS   = COLUMNS * LINES;
    localparam int TOP     = CELLS - COLUMNS;

    // Widths
    localparam int ADDR_W = $clog2(CELLS);
    localparam int CNT_W  = ADDR_W + 1;
    localparam int COL_W  = $clog2(COLUMNS);
    localparam int POS_W  = 11;
    localparam int IDX_W  = 11;
    localparam int WORD_W = 16;

    // Operation codes
    localparam logic [1:0] OP_PUT   = 2'd0;
    localparam logic [1:0] OP_CLEAR = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;

    // Character and color codes
    localparam logic [7:0] CODE_NEWLINE   = 8'd10;
    localparam logic [7:0] CODE_BACKSPACE = 8'd8;
    localparam logic [7:0] CODE_SPACE     = 8'h20;
    localparam logic [3:0] HUE_WHITE      = 4'd15;
    localparam logic [3:0] HUE_BLACK      = 4'd0;
    localparam logic [WORD_W-1:0] BLANK_CELL = {HUE_BLACK, HUE_WHITE, CODE_SPACE};

    // Cursor update request from the sequencer
    typedef struct packed {
        logic put;
        logic home;
    } cur_cmd_t;

    // Cursor status toward the sequencer
    typedef struct packed {
        logic [ADDR_W-1:0] lin;
        logic [ADDR_W-1:0] next_lin;
        logic [ADDR_W-1:0] put_addr;
        logic              put_we;
        logic              put_blank;
        logic              put_scroll;
    } cur_stat_t;

endpackage

// File: src/tcw_cell_ram.sv
// Cell store: single write port, single read port with registered read data.
module tcw_cell_ram (
    input  logic                        clk,
    input  logic                        we,
    input  logic [tcw_pkg::ADDR_W-1:0]  waddr,
    input  logic [tcw_pkg::WORD_W-1:0]  wdata,
    input  logic                        re,
    input  logic [tcw_pkg::ADDR_W-1:0]  raddr,
    output logic [tcw_pkg::WORD_W-1:0]  rdata
);
    import tcw_pkg::*;

    logic [WORD_W-1:0] mem [CELLS];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Read port, data held until the next read
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// File: src/tcw_cursor.sv
// Cursor registers and the put-character cursor arithmetic.
module tcw_cursor (
    input  logic                 clk,
    input  logic                 rst_n,
    input  tcw_pkg::cur_cmd_t    cmd,
    input  logic [7:0]           char_code,
    output tcw_pkg::cur_stat_t   stat
);
    import tcw_pkg::*;

    logic [ADDR_W-1:0] lin_reg;
    logic [COL_W-1:0]  col_reg;
    logic [CNT_W-1:0]  lin_ext;
    logic [COL_W-1:0]  col_next;
    logic [ADDR_W-1:0] put_addr;
    logic              put_we;
    logic              put_blank;
    logic              put_scroll;

    // Work out where a put leaves the cursor and which cell it writes
    always_comb
    begin
        lin_ext   = {1'b0, lin_reg};
        col_next  = col_reg;
        put_addr  = lin_reg;
        put_we    = 1'b0;
        put_blank = 1'b0;
        case (char_code)
            CODE_NEWLINE:
            begin
                lin_ext  = {1'b0, lin_reg} - CNT_W'(col_reg) + CNT_W'(COLUMNS);
                col_next = '0;
            end
            CODE_BACKSPACE:
            begin
                if (lin_reg != '0)
                begin
                    lin_ext   = {1'b0, lin_reg} - CNT_W'(1);
                    put_addr  = lin_reg - ADDR_W'(1);
                    put_we    = 1'b1;
                    put_blank = 1'b1;
                    col_next  = (col_reg == '0) ? COL_W'(COLUMNS - 1) : col_reg - COL_W'(1);
                end
            end
            default:
            begin
                lin_ext  = {1'b0, lin_reg} + CNT_W'(1);
                put_we   = 1'b1;
                col_next = (col_reg == COL_W'(COLUMNS - 1)) ? '0 : col_reg + COL_W'(1);
            end
        endcase
        put_scroll = (lin_ext >= CNT_W'(CELLS));
    end

    assign stat.lin        = lin_reg;
    assign stat.next_lin   = put_scroll ? ADDR_W'(TOP) : lin_ext[ADDR_W-1:0];
    assign stat.put_addr   = put_addr;
    assign stat.put_we     = put_we;
    assign stat.put_blank  = put_blank;
    assign stat.put_scroll = put_scroll;

    // Home on clear, advance on put, park at last row start on scroll
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lin_reg <= '0;
            col_reg <= '0;
        end
        else if (cmd.home)
        begin
            lin_reg <= '0;
            col_reg <= '0;
        end
        else if (cmd.put)
        begin
            lin_reg <= stat.next_lin;
            col_reg <= put_scroll ? '0 : col_next;
        end
    end

endmodule

// File: src/text_console_writer.sv
// Text console writer: sequencer over the cell store, cursor and result register.
// Put without scroll, unused operation, out-of-range read: result word registered from the
// execute state; in-range read: the store read is registered, then the result. A held result stalls.
// Put with scroll: copy pass over the store plus a blank of the last row, then the result.
// Clear: a fill pass over every cell, then the result. Next word only back in idle. Reset: cursor to 0,
// then a pass writes white-on-black blanks to every cell while in_ready stays low.
module text_console_writer (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [1:0]                  operation,
    input  logic [7:0]                  char_code,
    input  logic [3:0]                  fore_color,
    input  logic [3:0]                  back_color,
    input  logic [tcw_pkg::IDX_W-1:0]   cell_index,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [tcw_pkg::POS_W-1:0]   cursor_position,
    output logic [tcw_pkg::WORD_W-1:0]  cell_word
);
    import tcw_pkg::*;

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_EXEC   = 3'd1;
    localparam logic [2:0] ST_RDWAIT = 3'd2;
    localparam logic [2:0] ST_COPY   = 3'd3;
    localparam logic [2:0] ST_FILL   = 3'd4;
    localparam logic [2:0] ST_DONE   = 3'd5;

    logic [2:0]        state_reg, state_next;
    logic [1:0]        op_reg;
    logic [7:0]        code_reg;
    logic [3:0]        fg_reg;
    logic [3:0]        bg_reg;
    logic [IDX_W-1:0]  idx_reg;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              cpw_valid_reg, cpw_valid_next;
    logic [ADDR_W-1:0] cpw_addr_reg, cpw_addr_next;
    logic [WORD_W-1:0] fill_word_reg, fill_word_next;
    logic              fill_ack_reg, fill_ack_next;
    logic              out_valid_reg;
    logic [POS_W-1:0]  out_pos_reg;
    logic [WORD_W-1:0] out_word_reg;

    logic              slot_free;
    logic              accept;
    logic              emit;
    logic [POS_W-1:0]  emit_pos;
    logic [WORD_W-1:0] emit_word;

    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [WORD_W-1:0] ram_wdata;
    logic              ram_re;
    logic [ADDR_W-1:0] ram_raddr;
    logic [WORD_W-1:0] ram_rdata;

    cur_cmd_t  cur_cmd;
    cur_stat_t cur_stat;

    tcw_cell_ram u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    tcw_cursor u_cursor (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cur_cmd),
        .char_code (code_reg),
        .stat      (cur_stat)
    );

    assign in_ready  = (state_reg == ST_IDLE);
    assign accept    = in_valid && in_ready;
    assign slot_free = !out_valid_reg || out_ready;

    // Sequence one operation through the store
    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        cpw_valid_next = cpw_valid_reg;
        cpw_addr_next  = cpw_addr_reg;
        fill_word_next = fill_word_reg;
        fill_ack_next  = fill_ack_reg;
        cur_cmd        = '0;
        emit           = 1'b0;
        emit_pos       = POS_W'(cur_stat.lin);
        emit_word      = '0;
        ram_we         = 1'b0;
        ram_waddr      = cur_stat.put_addr;
        ram_wdata      = cur_stat.put_blank ? BLANK_CELL : {bg_reg, fg_reg, code_reg};
        ram_re         = 1'b0;
        ram_raddr      = ADDR_W'(idx_reg);
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                case (op_reg)
                    OP_PUT:
                    begin
                        if (cur_stat.put_scroll)
                        begin
                            cur_cmd.put    = 1'b1;
                            ram_we         = cur_stat.put_we;
                            cnt_next       = CNT_W'(COLUMNS);
                            cpw_valid_next = 1'b0;
                            fill_ack_next  = 1'b1;
                            state_next     = ST_COPY;
                        end
                        else if (slot_free)
                        begin
                            cur_cmd.put = 1'b1;
                            ram_we      = cur_stat.put_we;
                            emit        = 1'b1;
                            emit_pos    = POS_W'(cur_stat.next_lin);
                            state_next  = ST_IDLE;
                        end
                    end
                    OP_CLEAR:
                    begin
                        cur_cmd.home   = 1'b1;
                        fill_word_next = {bg_reg, fg_reg, CODE_SPACE};
                        cnt_next       = '0;
                        fill_ack_next  = 1'b1;
                        state_next     = ST_FILL;
                    end
                    OP_READ:
                    begin
                        if (32'(idx_reg) < 32'(CELLS))
                        begin
                            ram_re     = 1'b1;
                            state_next = ST_RDWAIT;
                        end
                        else if (slot_free)
                        begin
                            emit       = 1'b1;
                            state_next = ST_IDLE;
                        end
                    end
                    default:
                    begin
                        if (slot_free)
                        begin
                            emit       = 1'b1;
                            state_next = ST_IDLE;
                        end
                    end
                endcase
            end
            ST_RDWAIT:
            begin
                if (slot_free)
                begin
                    emit       = 1'b1;
                    emit_word  = ram_rdata;
                    state_next = ST_IDLE;
                end
            end
            ST_COPY:
            begin
                // Move each cell up one row: read source, write it in the next cycle
                ram_raddr = cnt_reg[ADDR_W-1:0];
                ram_waddr = cpw_addr_reg;
                ram_wdata = ram_rdata;
                ram_we    = cpw_valid_reg;
                if (cnt_reg < CNT_W'(CELLS))
                begin
                    ram_re         = 1'b1;
                    cnt_next       = cnt_reg + CNT_W'(1);
                    cpw_valid_next = 1'b1;
                    cpw_addr_next  = ADDR_W'(cnt_reg - CNT_W'(COLUMNS));
                end
                else
                begin
                    cpw_valid_next = 1'b0;
                    cnt_next       = CNT_W'(TOP);
                    fill_word_next = BLANK_CELL;
                    state_next     = ST_FILL;
                end
            end
            ST_FILL:
            begin
                ram_we    = 1'b1;
                ram_waddr = cnt_reg[ADDR_W-1:0];
                ram_wdata = fill_word_reg;
                cnt_next  = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(CELLS - 1))
                begin
                    state_next = fill_ack_reg ? ST_DONE : ST_IDLE;
                end
            end
            ST_DONE:
            begin
                if (slot_free)
                begin
                    emit       = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers; reset starts the blanking pass
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_FILL;
            cnt_reg       <= '0;
            cpw_valid_reg <= 1'b0;
            fill_word_reg <= BLANK_CELL;
            fill_ack_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            cpw_valid_reg <= cpw_valid_next;
            fill_word_reg <= fill_word_next;
            fill_ack_reg  <= fill_ack_next;
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Capture the input word, the result word and the copy write address
    always_ff @(posedge clk)
    begin
        cpw_addr_reg <= cpw_addr_next;
        if (accept)
        begin
            op_reg   <= operation;
            code_reg <= char_code;
            fg_reg   <= fore_color;
            bg_reg   <= back_color;
            idx_reg  <= cell_index;
        end
        if (emit)
        begin
            out_pos_reg  <= emit_pos;
            out_word_reg <= emit_word;
        end
    end

    assign out_valid       = out_valid_reg;
    assign cursor_position = out_pos_reg;
    assign cell_word       = out_word_reg;

`ifndef SYNTHESIS
    // Cursor never rests outside the store
    a_cursor_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        32'(cur_stat.lin) < 32'(CELLS))
        else $error("cursor outside cell store");

    // One word at a time: an accepted word blocks the input next cycle
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> !in_ready)
        else $error("input accepted while previous word in progress");

    // Copy writes never land on the cell being read
    a_copy_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_COPY) && cpw_valid_reg && ram_re |-> cpw_addr_reg != ram_raddr)
        else $error("scroll copy overlaps read and write");

    // A result appears only as the sequencer returns to idle
    a_emit_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
        emit |=> state_reg == ST_IDLE)
        else $error("result issued without finishing operation");
`endif

endmodule
